/* rtl/core/drld_pkg.sv */
package drld_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] RUN_LIMIT_RESET = 8'd64;
  localparam logic [3:0] MAX_FIELD_BYTES = 4'd8;

  // result status codes
  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_END   = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  typedef enum logic [1:0] {
    OP_HDR,
    OP_LEN,
    OP_OFF,
    OP_TERM
  } op_kind_e;

  // one classified byte, handed from the front to the back
  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] data;
    logic [2:0] pos;
    logic       fin;
    logic       restart;
    logic [1:0] status;
    logic [7:0] index;
  } op_t;

endpackage

/* rtl/core/drld_in_if.sv */
interface drld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       list_start;

  modport source (output valid, output data_byte, output list_start, input ready);
  modport sink (input valid, input data_byte, input list_start, output ready);
endinterface

/* rtl/core/drld_out_if.sv */
interface drld_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] run_offset;
  logic [63:0] run_length;
  logic [7:0]  run_index;
  logic        sparse;
  logic [1:0]  status;
  logic        last;

  modport source (
    output valid, output run_offset, output run_length, output run_index,
    output sparse, output status, output last, input ready
  );
  modport sink (
    input valid, input run_offset, input run_length, input run_index,
    input sparse, input status, input last, output ready
  );
endinterface

/* rtl/core/drld_cfg_if.sv */
interface drld_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] run_limit;

  modport source (output valid, output run_limit, input ready);
  modport sink (input valid, input run_limit, output ready);
endinterface

/* rtl/core/data_run_list_decoder.sv */
// channel  dir  signals                                          transfer
// in_i     in   data_byte[7:0], list_start                       valid & ready
// out_o    out  run_offset[63:0], run_length[63:0], run_index,   valid & ready
//               sparse, status[1:0], last
// cfg_i    in   run_limit[7:0]                                   valid & ready
//
// One byte a cycle sustained while out_o is ready; the byte that finishes a
// result is registered in the queue, then the result in the output register.
// The back does one 64-bit add, the cluster offset update, per offset field.
// Reset is asynchronous, active low; run_limit comes up as 64, decoder idle.
// Stalls on out_o fill the queue, then in_i.ready drops; bytes outside a
// list are taken and dropped.
module data_run_list_decoder #(
  parameter int unsigned QueueDepth = drld_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  drld_in_if.sink    in_i,
  drld_cfg_if.sink   cfg_i,
  drld_out_if.source out_o
);
  import drld_pkg::*;

  logic op_valid, op_ready;
  logic q_valid, q_ready;
  op_t  op, q_op;

  drld_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_i      (cfg_i),
    .op_valid_o (op_valid),
    .op_ready_i (op_ready),
    .op_o       (op)
  );

  drld_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (op_valid),
    .push_ready_o (op_ready),
    .push_op_i    (op),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_op_o     (q_op)
  );

  drld_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (q_valid),
    .op_ready_o (q_ready),
    .op_i       (q_op),
    .out_o      (out_o)
  );

endmodule

/* rtl/core/drld_front.sv */
module drld_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  drld_in_if.sink        in_i,
  drld_cfg_if.sink       cfg_i,
  output logic           op_valid_o,
  input  logic           op_ready_i,
  output drld_pkg::op_t  op_o
);
  import drld_pkg::*;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_LENGTH = 2'd2;
  localparam logic [1:0] PH_OFFSET = 2'd3;

  logic [1:0] phase_q, phase_d, phase_eff;
  logic [3:0] len_left_q, len_left_d;
  logic [3:0] off_left_q, off_left_d;
  logic [2:0] pos_q, pos_d;
  logic [7:0] runs_q, runs_d, runs_eff, runs_inc;
  logic [7:0] limit_q;
  logic [3:0] lsz, osz;
  logic       take, limit_hit;

  assign in_i.ready  = op_ready_i;
  assign cfg_i.ready = 1'b1;
  assign take        = in_i.valid && op_ready_i;

  assign phase_eff = in_i.list_start ? PH_HEADER : phase_q;
  assign runs_eff  = in_i.list_start ? 8'd0 : runs_q;
  assign runs_inc  = runs_eff + 8'd1;
  assign limit_hit = runs_inc >= limit_q;
  assign lsz       = in_i.data_byte[3:0];
  assign osz       = in_i.data_byte[7:4];

  // idle bytes are dropped here and never reach the queue
  assign op_valid_o = in_i.valid && (phase_eff != PH_IDLE);

  always_comb begin
    phase_d    = phase_q;
    len_left_d = len_left_q;
    off_left_d = off_left_q;
    pos_d      = pos_q;
    runs_d     = runs_q;

    op_o.kind    = OP_HDR;
    op_o.data    = in_i.data_byte;
    op_o.pos     = pos_q;
    op_o.fin     = 1'b0;
    op_o.restart = in_i.list_start;
    op_o.status  = ST_RUN;
    op_o.index   = runs_eff;

    unique case (phase_eff)
      PH_HEADER: begin
        if (in_i.data_byte == 8'd0) begin
          op_o.kind   = OP_TERM;
          op_o.status = ST_END;
          phase_d     = PH_IDLE;
        end else if (lsz == 4'd0 || lsz > MAX_FIELD_BYTES || osz > MAX_FIELD_BYTES) begin
          op_o.kind   = OP_TERM;
          op_o.status = ST_BAD;
          phase_d     = PH_IDLE;
        end else begin
          len_left_d = lsz;
          off_left_d = osz;
          pos_d      = 3'd0;
          phase_d    = PH_LENGTH;
        end
        runs_d = runs_eff;
      end
      PH_LENGTH: begin
        op_o.kind  = OP_LEN;
        pos_d      = pos_q + 3'd1;
        len_left_d = len_left_q - 4'd1;
        if (len_left_q == 4'd1) begin
          if (off_left_q == 4'd0) begin
            op_o.fin    = 1'b1;
            op_o.status = limit_hit ? ST_LIMIT : ST_RUN;
            runs_d      = runs_inc;
            phase_d     = limit_hit ? PH_IDLE : PH_HEADER;
          end else begin
            pos_d   = 3'd0;
            phase_d = PH_OFFSET;
          end
        end
      end
      PH_OFFSET: begin
        op_o.kind  = OP_OFF;
        pos_d      = pos_q + 3'd1;
        off_left_d = off_left_q - 4'd1;
        if (off_left_q == 4'd1) begin
          op_o.fin    = 1'b1;
          op_o.status = limit_hit ? ST_LIMIT : ST_RUN;
          runs_d      = runs_inc;
          phase_d     = limit_hit ? PH_IDLE : PH_HEADER;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      len_left_q <= 4'd0;
      off_left_q <= 4'd0;
      pos_q      <= 3'd0;
      runs_q     <= 8'd0;
    end else if (take) begin
      phase_q    <= phase_d;
      len_left_q <= len_left_d;
      off_left_q <= off_left_d;
      pos_q      <= pos_d;
      runs_q     <= runs_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= RUN_LIMIT_RESET;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.run_limit;
    end
  end

endmodule

/* rtl/core/drld_fifo.sv */
module drld_fifo #(
  parameter int unsigned Depth = drld_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  drld_pkg::op_t  push_op_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output drld_pkg::op_t  pop_op_o
);
  import drld_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  op_t             mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_op_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue occupancy beyond depth");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue count missed a transfer in");
  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> count_q == $past(count_q) - CntW'(1))
    else $error("queue count missed a transfer out");
  a_ptr_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> wr_ptr_q == rd_ptr_q)
    else $error("empty queue with pointers apart");
`endif

endmodule

/* rtl/core/drld_back.sv */
module drld_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           op_valid_i,
  output logic           op_ready_o,
  input  drld_pkg::op_t  op_i,
  drld_out_if.source     out_o
);
  import drld_pkg::*;

  logic [63:0] len_acc_q, len_acc_d;
  logic [63:0] delta_acc_q, delta_acc_d;
  logic [63:0] cluster_q, cluster_d;
  logic [63:0] shifted, hi_mask, delta_ext;
  logic [6:0]  hi_shift;
  logic        out_valid_q;
  logic [63:0] offset_q, length_q;
  logic [7:0]  index_q;
  logic        sparse_q;
  logic [1:0]  status_q;
  logic        pop, emit;

  assign op_ready_o = !out_valid_q || out_o.ready;
  assign pop        = op_valid_i && op_ready_o;
  assign emit       = op_i.fin || (op_i.kind == OP_TERM);

  assign shifted  = {56'd0, op_i.data} << {op_i.pos, 3'b000};
  // bits above the last delta byte take its sign; none when all eight are there
  assign hi_shift = {1'b0, op_i.pos, 3'b000} + 7'd8;
  assign hi_mask  = {64{1'b1}} << hi_shift;

  always_comb begin
    len_acc_d   = len_acc_q;
    delta_acc_d = delta_acc_q;
    cluster_d   = cluster_q;
    delta_ext   = '0;
    unique case (op_i.kind)
      OP_LEN: begin
        len_acc_d = ((op_i.pos == 3'd0) ? 64'd0 : len_acc_q) | shifted;
      end
      OP_OFF: begin
        delta_acc_d = ((op_i.pos == 3'd0) ? 64'd0 : delta_acc_q) | shifted;
        delta_ext   = delta_acc_d | (op_i.data[7] ? hi_mask : 64'd0);
        if (op_i.fin) begin
          cluster_d = cluster_q + delta_ext;
        end
      end
      OP_HDR, OP_TERM: begin
        if (op_i.restart) begin
          cluster_d = '0;
        end
      end
      default: begin
        cluster_d = cluster_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_acc_q   <= '0;
      delta_acc_q <= '0;
      cluster_q   <= '0;
    end else if (pop) begin
      len_acc_q   <= len_acc_d;
      delta_acc_q <= delta_acc_d;
      cluster_q   <= cluster_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && emit) begin
      index_q  <= op_i.index;
      status_q <= op_i.status;
      if (op_i.kind == OP_TERM) begin
        offset_q <= '0;
        length_q <= '0;
        sparse_q <= 1'b0;
      end else begin
        offset_q <= cluster_d;
        length_q <= len_acc_d;
        sparse_q <= op_i.kind == OP_LEN;
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.run_offset = offset_q;
  assign out_o.run_length = length_q;
  assign out_o.run_index  = index_q;
  assign out_o.sparse     = sparse_q;
  assign out_o.status     = status_q;
  assign out_o.last       = status_q != ST_RUN;

`ifndef SYNTHESIS
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !pop)
    else $error("pending result overwritten");
  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && emit |=> out_valid_q)
    else $error("finished run not presented");
  a_term_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && op_i.kind == OP_TERM |=> offset_q == 64'd0 && length_q == 64'd0 && !sparse_q)
    else $error("end result carries run data");
`endif

endmodule
